// File: src/plm_pkg.sv
// Package for the piecewise linear modulus evaluator.
// Holds the shared widths, constants, register codes and pipeline payload types.
// No dependencies.
`default_nettype none

package plm_pkg;

  // Field widths.
  localparam int unsigned TEMP_W    = 17;
  localparam int unsigned MOD_W     = 16;
  localparam int unsigned KELVIN_W  = 16;
  localparam int unsigned IDX_W     = 20;
  localparam int unsigned SPAN_W    = 17;
  localparam int unsigned PERTURB_W = 11;
  localparam int unsigned SCALED_W  = MOD_W + PERTURB_W;
  localparam int unsigned DIV_STEPS = MOD_W;

  // APB register port.
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  // Offset from kelvin to Celsius, 273.125 K in Q4.
  localparam logic signed [TEMP_W-1:0] KELVIN_OFFSET_Q4 = 17'sd4370;

  // Perturbation factor in Q8.
  localparam logic [PERTURB_W-1:0] PERTURB_Q8 = 11'd256;

  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic [MOD_W-1:0]         mod_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [SPAN_W-1:0]        span_t;

  // Reset values of the configuration registers.
  localparam temp_t BREAK_ONE_RST   = 17'sd400;
  localparam temp_t BREAK_TWO_RST   = 17'sd15040;
  localparam temp_t BREAK_THREE_RST = 17'sd19440;
  localparam temp_t BREAK_FOUR_RST  = 17'sd25600;
  localparam mod_t  MOD_ONE_RST     = 16'd6848;
  localparam mod_t  MOD_TWO_RST     = 16'd6000;
  localparam mod_t  MOD_THREE_RST   = 16'd5440;
  localparam mod_t  MOD_FOUR_RST    = 16'd3168;

  // Register indexes, at byte address four times the index.
  typedef enum logic [2:0] {
    REG_BREAK_ONE   = 3'd0,
    REG_BREAK_TWO   = 3'd1,
    REG_BREAK_THREE = 3'd2,
    REG_BREAK_FOUR  = 3'd3,
    REG_MOD_ONE     = 3'd4,
    REG_MOD_TWO     = 3'd5,
    REG_MOD_THREE   = 3'd6,
    REG_MOD_FOUR    = 3'd7
  } reg_idx_e;

  // Curve configuration handed from the register file to the datapath.
  typedef struct packed {
    temp_t break_one;
    temp_t break_two;
    temp_t break_three;
    temp_t break_four;
    mod_t  mod_one;
    mod_t  mod_two;
    mod_t  mod_three;
    mod_t  mod_four;
  } cfg_t;

  // Payload of one divider stage. The upper numerator bits still to be
  // consumed sit at the top of nq; quotient bits shift in at the bottom.
  typedef struct packed {
    span_t rem;
    mod_t  nq;
    span_t den;
    logic  neg;
    mod_t  base;
    idx_t  idx;
  } div_data_t;

endpackage

`default_nettype wire

// File: src/plm_regs.sv
// APB register file for the curve breakpoints and moduli.
// Depends on plm_pkg.
`default_nettype none

module plm_regs
  import plm_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg_o
);

  temp_t break_one_q, break_two_q, break_three_q, break_four_q;
  mod_t  mod_one_q, mod_two_q, mod_three_q, mod_four_q;
  reg_idx_e reg_idx;
  logic     wr_en;

  // Word addressing; the byte offset within a word is ignored.
  assign reg_idx = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  // Register writes complete in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      break_one_q   <= BREAK_ONE_RST;
      break_two_q   <= BREAK_TWO_RST;
      break_three_q <= BREAK_THREE_RST;
      break_four_q  <= BREAK_FOUR_RST;
      mod_one_q     <= MOD_ONE_RST;
      mod_two_q     <= MOD_TWO_RST;
      mod_three_q   <= MOD_THREE_RST;
      mod_four_q    <= MOD_FOUR_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BREAK_ONE:   break_one_q   <= temp_t'(pwdata[TEMP_W-1:0]);
        REG_BREAK_TWO:   break_two_q   <= temp_t'(pwdata[TEMP_W-1:0]);
        REG_BREAK_THREE: break_three_q <= temp_t'(pwdata[TEMP_W-1:0]);
        REG_BREAK_FOUR:  break_four_q  <= temp_t'(pwdata[TEMP_W-1:0]);
        REG_MOD_ONE:     mod_one_q     <= pwdata[MOD_W-1:0];
        REG_MOD_TWO:     mod_two_q     <= pwdata[MOD_W-1:0];
        REG_MOD_THREE:   mod_three_q   <= pwdata[MOD_W-1:0];
        REG_MOD_FOUR:    mod_four_q    <= pwdata[MOD_W-1:0];
        default:         break_one_q   <= break_one_q;
      endcase
    end
  end

  // Read data, zero extended to the bus width.
  always_comb begin
    unique case (reg_idx)
      REG_BREAK_ONE:   prdata = PDATA_W'(unsigned'(break_one_q));
      REG_BREAK_TWO:   prdata = PDATA_W'(unsigned'(break_two_q));
      REG_BREAK_THREE: prdata = PDATA_W'(unsigned'(break_three_q));
      REG_BREAK_FOUR:  prdata = PDATA_W'(unsigned'(break_four_q));
      REG_MOD_ONE:     prdata = PDATA_W'(mod_one_q);
      REG_MOD_TWO:     prdata = PDATA_W'(mod_two_q);
      REG_MOD_THREE:   prdata = PDATA_W'(mod_three_q);
      REG_MOD_FOUR:    prdata = PDATA_W'(mod_four_q);
      default:         prdata = '0;
    endcase
  end

  always_comb begin
    cfg_o.break_one   = break_one_q;
    cfg_o.break_two   = break_two_q;
    cfg_o.break_three = break_three_q;
    cfg_o.break_four  = break_four_q;
    cfg_o.mod_one     = mod_one_q;
    cfg_o.mod_two     = mod_two_q;
    cfg_o.mod_three   = mod_three_q;
    cfg_o.mod_four    = mod_four_q;
  end

endmodule

`default_nettype wire

// File: src/plm_front.sv
// Front end of the evaluator: Celsius conversion, segment selection,
// span computation and the numerator product, over three register stages.
// Depends on plm_pkg.
`default_nettype none

module plm_front
  import plm_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cfg_t                cfg_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [KELVIN_W-1:0] temp_kelvin_i,
  input  wire idx_t                cell_index_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output div_data_t                out_data_o
);

  // Stage A: selected segment.
  logic  a_valid_q, a_clamp_q;
  temp_t a_t_q, a_t0_q, a_t1_q;
  mod_t  a_e0_q, a_e1_q;
  idx_t  a_idx_q;

  // Stage B: spans and modulus step.
  logic  b_valid_q, b_neg_q;
  span_t b_dt_q, b_den_q;
  mod_t  b_mag_q, b_base_q;
  idx_t  b_idx_q;

  // Stage C: numerator product ready for the divider.
  logic      c_valid_q;
  div_data_t c_data_q;

  logic a_ready, b_ready, c_ready;

  // Each stage moves on when it is empty or its successor moves on.
  assign c_ready    = !c_valid_q || out_ready_i;
  assign b_ready    = !b_valid_q || c_ready;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  // Temperature in Celsius Q4 and the segment it falls into.
  temp_t t_c, sel_t0, sel_t1;
  mod_t  sel_e0, sel_e1;
  logic  sel_clamp;

  assign t_c = temp_t'({1'b0, temp_kelvin_i}) - KELVIN_OFFSET_Q4;

  always_comb begin
    sel_clamp = 1'b0;
    sel_t0    = cfg_i.break_one;
    sel_t1    = cfg_i.break_two;
    sel_e0    = cfg_i.mod_one;
    sel_e1    = cfg_i.mod_two;
    if (t_c <= cfg_i.break_one) begin
      sel_clamp = 1'b1;
    end else if (t_c <= cfg_i.break_two) begin
      sel_t0 = cfg_i.break_one;
    end else if (t_c <= cfg_i.break_three) begin
      sel_t0 = cfg_i.break_two;
      sel_t1 = cfg_i.break_three;
      sel_e0 = cfg_i.mod_two;
      sel_e1 = cfg_i.mod_three;
    end else if (t_c <= cfg_i.break_four) begin
      sel_t0 = cfg_i.break_three;
      sel_t1 = cfg_i.break_four;
      sel_e0 = cfg_i.mod_three;
      sel_e1 = cfg_i.mod_four;
    end else begin
      sel_clamp = 1'b1;
      sel_e0    = cfg_i.mod_four;
    end
  end

  // Stage B arithmetic. Within a chosen segment t0 < t <= t1, so both spans
  // are positive and fit the unsigned span width.
  logic [SPAN_W:0]   dt_w, den_w;
  logic [MOD_W:0]    de_w, de_abs;

  assign dt_w   = {a_t_q[TEMP_W-1], a_t_q} - {a_t0_q[TEMP_W-1], a_t0_q};
  assign den_w  = {a_t1_q[TEMP_W-1], a_t1_q} - {a_t0_q[TEMP_W-1], a_t0_q};
  assign de_w   = {1'b0, a_e1_q} - {1'b0, a_e0_q};
  assign de_abs = de_w[MOD_W] ? (~de_w + (MOD_W+1)'(1)) : de_w;

  // Stage C product: magnitude of the step times the offset into the segment.
  logic [MOD_W+SPAN_W-1:0] prod_w;

  assign prod_w = (MOD_W+SPAN_W)'(b_mag_q) * (MOD_W+SPAN_W)'(b_dt_q);

  // Control of the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= in_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
      if (c_ready) begin
        c_valid_q <= b_valid_q;
      end
    end
  end

  // Payload of the three stages.
  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_clamp_q <= sel_clamp;
      a_t_q     <= t_c;
      a_t0_q    <= sel_t0;
      a_t1_q    <= sel_t1;
      a_e0_q    <= sel_e0;
      a_e1_q    <= sel_e1;
      a_idx_q   <= cell_index_i;
    end
    if (b_ready && a_valid_q) begin
      // A clamped item takes the base modulus with a zero step.
      if (a_clamp_q) begin
        b_dt_q  <= '0;
        b_den_q <= span_t'(1);
        b_mag_q <= '0;
        b_neg_q <= 1'b0;
      end else begin
        b_dt_q  <= dt_w[SPAN_W-1:0];
        b_den_q <= den_w[SPAN_W-1:0];
        b_mag_q <= de_abs[MOD_W-1:0];
        b_neg_q <= de_w[MOD_W];
      end
      b_base_q <= a_e0_q;
      b_idx_q  <= a_idx_q;
    end
    if (c_ready && b_valid_q) begin
      // The product is below den * 2^16, so its upper bits are below den.
      c_data_q.rem  <= prod_w[MOD_W+SPAN_W-1:MOD_W];
      c_data_q.nq   <= prod_w[MOD_W-1:0];
      c_data_q.den  <= b_den_q;
      c_data_q.neg  <= b_neg_q;
      c_data_q.base <= b_base_q;
      c_data_q.idx  <= b_idx_q;
    end
  end

  assign out_valid_o = c_valid_q;
  assign out_data_o  = c_data_q;

endmodule

`default_nettype wire

// File: src/plm_div_stage.sv
// One restoring division step: produces one quotient bit per register stage.
// Depends on plm_pkg.
`default_nettype none

module plm_div_stage
  import plm_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire div_data_t in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output div_data_t      out_data_o
);

  logic      valid_q;
  div_data_t data_q;
  div_data_t data_d;
  logic [SPAN_W:0] trial, diff;
  logic            fits;

  assign in_ready_o = !valid_q || out_ready_i;

  // Bring down the next numerator bit and subtract the divisor if it fits.
  assign trial = {in_data_i.rem, in_data_i.nq[MOD_W-1]};
  assign diff  = trial - {1'b0, in_data_i.den};
  assign fits  = trial >= {1'b0, in_data_i.den};

  always_comb begin
    data_d     = in_data_i;
    data_d.rem = fits ? diff[SPAN_W-1:0] : trial[SPAN_W-1:0];
    data_d.nq  = {in_data_i.nq[MOD_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

// File: src/plm_finish.sv
// Output stage: applies the signed quotient to the base modulus, scales by
// the perturbation factor, saturates and holds the result for the consumer.
// Depends on plm_pkg.
`default_nettype none

module plm_finish
  import plm_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire div_data_t in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output mod_t           modulus_o,
  output idx_t           cell_index_out_o
);

  logic valid_q;
  mod_t modulus_q;
  idx_t idx_q;

  logic [MOD_W+1:0]    base_x, quot_x, nom_w;
  mod_t                nom_c;
  logic [SCALED_W-1:0] scaled_w;
  logic [SCALED_W-9:0] shifted_w;
  mod_t                modulus_d;

  assign in_ready_o = !valid_q || out_ready_i;

  // Nominal value, kept within the modulus range.
  assign base_x = (MOD_W+2)'(in_data_i.base);
  assign quot_x = (MOD_W+2)'(in_data_i.nq);
  assign nom_w  = in_data_i.neg ? (base_x - quot_x) : (base_x + quot_x);

  always_comb begin
    if (nom_w[MOD_W+1]) begin
      nom_c = '0;
    end else if (nom_w[MOD_W]) begin
      nom_c = '1;
    end else begin
      nom_c = nom_w[MOD_W-1:0];
    end
  end

  // Perturbation in Q8, truncated, then saturated.
  assign scaled_w  = SCALED_W'(nom_c) * SCALED_W'(PERTURB_Q8);
  assign shifted_w = scaled_w[SCALED_W-1:8];
  assign modulus_d = (|shifted_w[SCALED_W-9:MOD_W]) ? '1 : shifted_w[MOD_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      modulus_q <= modulus_d;
      idx_q     <= in_data_i.idx;
    end
  end

  assign out_valid_o      = valid_q;
  assign modulus_o        = modulus_q;
  assign cell_index_out_o = idx_q;

endmodule

`default_nettype wire

// File: src/piecewise_linear_modulus.sv
// Piecewise linear modulus evaluator, top level.
// Pipeline: three front stages, one divider stage per quotient bit for 16 bits,
// and one output stage.
// Throughput: one request per cycle while out_ready_i is held high; every stage is an elastic register.
// Reset: asynchronous, active low; empties the pipeline and loads the default curve.
// Depends on plm_pkg, plm_regs, plm_front, plm_div_stage and plm_finish.
`default_nettype none

module piecewise_linear_modulus
  import plm_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PADDR_W-1:0]  paddr,
  input  wire logic [PDATA_W-1:0]  pwdata,
  output logic      [PDATA_W-1:0]  prdata,
  output logic                     pready,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [KELVIN_W-1:0] temp_kelvin_i,
  input  wire logic [IDX_W-1:0]    cell_index_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [MOD_W-1:0]         modulus_o,
  output logic [IDX_W-1:0]         cell_index_out_o
);

  cfg_t      cfg;
  logic      div_valid [DIV_STEPS+1];
  logic      div_ready [DIV_STEPS+1];
  div_data_t div_data  [DIV_STEPS+1];

  // Configuration registers.
  plm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Segment selection and numerator product.
  plm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .temp_kelvin_i (temp_kelvin_i),
    .cell_index_i  (cell_index_i),
    .out_valid_o   (div_valid[0]),
    .out_ready_i   (div_ready[0]),
    .out_data_o    (div_data[0])
  );

  // Pipelined divider, one quotient bit per stage.
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    plm_div_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (div_valid[s]),
      .in_ready_o  (div_ready[s]),
      .in_data_i   (div_data[s]),
      .out_valid_o (div_valid[s+1]),
      .out_ready_i (div_ready[s+1]),
      .out_data_o  (div_data[s+1])
    );
  end

  // Final correction, scaling and output register.
  plm_finish u_finish (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (div_valid[DIV_STEPS]),
    .in_ready_o       (div_ready[DIV_STEPS]),
    .in_data_i        (div_data[DIV_STEPS]),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .modulus_o        (modulus_o),
    .cell_index_out_o (cell_index_out_o)
  );

endmodule

`default_nettype wire

// File: bench/piecewise_linear_modulus_test.sv
// Self-checking bench for the piecewise linear modulus evaluator: APB curve set-up,
// valid/ready request and result streams, and a scoreboard that predicts each modulus.
// Depends on plm_pkg and piecewise_linear_modulus.

module piecewise_linear_modulus_test;
  timeunit 1ns;
  timeprecision 1ps;

  import plm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 240;
  localparam int REPORT_CAP  = 40;

  typedef struct {
    mod_t modulus;
    idx_t cell_idx;
  } modulus_result_t;

  // Holds a copy of the curve registers, predicts the modulus of every
  // accepted request and checks results against the oldest prediction.
  class modulus_scoreboard;
    temp_t           brk [4];
    mod_t            lvl [4];
    modulus_result_t awaited [$];
    int              mismatches;

    function new();
      brk = '{BREAK_ONE_RST, BREAK_TWO_RST, BREAK_THREE_RST, BREAK_FOUR_RST};
      lvl = '{MOD_ONE_RST, MOD_TWO_RST, MOD_THREE_RST, MOD_FOUR_RST};
      mismatches = 0;
    endfunction

    // Only the low bits of a written word land in the register.
    function void set_register(reg_idx_e r, logic [PDATA_W-1:0] value);
      case (r)
        REG_BREAK_ONE:   brk[0] = value[TEMP_W-1:0];
        REG_BREAK_TWO:   brk[1] = value[TEMP_W-1:0];
        REG_BREAK_THREE: brk[2] = value[TEMP_W-1:0];
        REG_BREAK_FOUR:  brk[3] = value[TEMP_W-1:0];
        REG_MOD_ONE:     lvl[0] = value[MOD_W-1:0];
        REG_MOD_TWO:     lvl[1] = value[MOD_W-1:0];
        REG_MOD_THREE:   lvl[2] = value[MOD_W-1:0];
        REG_MOD_FOUR:    lvl[3] = value[MOD_W-1:0];
        default: ;
      endcase
    endfunction

    // Celsius conversion, ordered segment search, interpolation truncated
    // toward zero, then perturbation and saturation.
    function mod_t curve_modulus(logic [KELVIN_W-1:0] kelvin);
      longint t, nominal, scaled;
      longint bp [4];
      longint md [4];
      int     seg, i;
      t = longint'(kelvin) - longint'(KELVIN_OFFSET_Q4);
      for (i = 0; i < 4; i++) begin
        bp[i] = longint'(brk[i]);
        md[i] = longint'(lvl[i]);
      end
      // The first breakpoint at or above T picks the segment.
      seg = 4;
      for (i = 3; i >= 0; i--) begin
        if (t <= bp[i]) seg = i;
      end
      if (seg == 0) begin
        nominal = md[0];
      end else if (seg == 4) begin
        nominal = md[3];
      end else begin
        nominal = md[seg-1] + ((md[seg] - md[seg-1]) * (t - bp[seg-1])) /
                  (bp[seg] - bp[seg-1]);
      end
      if (nominal < 0) nominal = 0;
      if (nominal > 65535) nominal = 65535;
      scaled = (nominal * longint'(PERTURB_Q8)) >>> 8;
      if (scaled > 65535) scaled = 65535;
      return mod_t'(scaled);
    endfunction

    function void note_request(logic [KELVIN_W-1:0] kelvin, idx_t cell_idx);
      modulus_result_t r;
      r.modulus  = curve_modulus(kelvin);
      r.cell_idx = cell_idx;
      awaited.push_back(r);
    endfunction

    function void check_result(mod_t modulus, idx_t cell_idx);
      modulus_result_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $display("%0t: result with nothing expected: modulus %0d cell %0d",
                   $time, modulus, cell_idx);
        return;
      end
      want = awaited.pop_front();
      if (modulus !== want.modulus) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $display("%0t: modulus mismatch: expected %0d, got %0d (cell %0d)",
                   $time, want.modulus, modulus, want.cell_idx);
      end
      if (cell_idx !== want.cell_idx) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $display("%0t: cell index mismatch: expected %0d, got %0d",
                   $time, want.cell_idx, cell_idx);
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [KELVIN_W-1:0] temp_kelvin_i;
  idx_t                cell_index_i;
  logic                out_valid_o;
  logic                out_ready_i;
  mod_t                modulus_o;
  idx_t                cell_index_out_o;

  modulus_scoreboard sb;
  int                send_idle_pct;
  int                stall_pct;
  int                cycles;

  piecewise_linear_modulus dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .temp_kelvin_i    (temp_kelvin_i),
    .cell_index_i     (cell_index_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .modulus_o        (modulus_o),
    .cell_index_out_o (cell_index_out_o)
  );

  // Clock with a 2 ns period.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // The result side stalls at random, at the rate of the current phase.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Accepted requests feed the scoreboard; accepted results are checked.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (in_valid_i && in_ready_o) sb.note_request(temp_kelvin_i, cell_index_i);
      if (out_valid_o && out_ready_i) sb.check_result(modulus_o, cell_index_out_o);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("piecewise_linear_modulus_test: done, errors");
      $finish;
    end
  end

  // One APB write: setup cycle, then access cycle until pready. The select
  // is left high so that writes can follow back to back.
  task automatic write_register(reg_idx_e r, logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_register(r, value);
  endtask

  // Loads one of the curve settings; random upper bits check the masking.
  task automatic load_curve(int which);
    temp_t             b [4];
    mod_t              m [4];
    logic [PDATA_W-1:0] word;
    int                i;
    for (i = 0; i < 4; i++) m[i] = mod_t'($urandom);
    case (which)
      0: begin
        b = '{BREAK_ONE_RST, BREAK_TWO_RST, BREAK_THREE_RST, BREAK_FOUR_RST};
        m = '{MOD_ONE_RST, MOD_TWO_RST, MOD_THREE_RST, MOD_FOUR_RST};
      end
      1: begin
        // Steepest slopes across the whole Celsius range.
        b = '{-17'sd4370, -17'sd4369, 17'sd61164, 17'sd61165};
        m = '{16'd0, 16'd65535, 16'd0, 16'd65535};
      end
      2: begin
        // Breakpoints at the limits of the register width.
        b = '{-17'sd65536, -17'sd4370, 17'sd61165, 17'sd65535};
        m = '{16'd65535, 16'd0, 16'd65535, 16'd0};
      end
      3: b = '{17'sd8000, 17'sd8000, 17'sd8000, 17'sd8000};
      4: b = '{17'sd20000, 17'sd5000, 17'sd30000, 17'sd10000};
      5: begin
        b[0] = temp_t'(-4370 + int'($urandom_range(20000)));
        for (i = 1; i < 4; i++) b[i] = b[i-1] + temp_t'($urandom_range(15000));
      end
      6: begin
        b = '{17'sd100, 17'sd101, 17'sd102, 17'sd103};
        m = '{16'd0, 16'd65535, 16'd1, 16'd65534};
      end
      default: begin
        for (i = 0; i < 4; i++) b[i] = temp_t'($urandom);
      end
    endcase
    for (i = 0; i < 4; i++) begin
      word = $urandom;
      word[TEMP_W-1:0] = b[i];
      write_register(reg_idx_e'(REG_BREAK_ONE + i), word);
    end
    for (i = 0; i < 4; i++) begin
      word = $urandom;
      word[MOD_W-1:0] = m[i];
      write_register(reg_idx_e'(REG_MOD_ONE + i), word);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Presents one request and holds it until it is accepted. Valid is only
  // lowered when a gap is taken, so back-to-back requests keep it high.
  task automatic send_request(logic [KELVIN_W-1:0] kelvin, idx_t cell_idx);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i    <= 1'b1;
    temp_kelvin_i <= kelvin;
    cell_index_i  <= cell_idx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Mostly temperatures close to a breakpoint or inside the curve's span,
  // the rest spread over the full kelvin range.
  task automatic send_random_item();
    logic [KELVIN_W-1:0] kelvin;
    idx_t                cell_idx;
    longint              t, lo, hi;
    int                  pick;
    pick     = $urandom_range(9);
    kelvin   = KELVIN_W'($urandom_range(65535));
    cell_idx = idx_t'($urandom);
    if ($urandom_range(15) == 0) cell_idx = $urandom_range(1) ? '1 : '0;
    if (pick >= 4 && pick <= 7) begin
      t = longint'(sb.brk[$urandom_range(3)]) + longint'(KELVIN_OFFSET_Q4) +
          longint'($urandom_range(16)) - 8;
      if (t >= 0 && t <= 65535) kelvin = t[KELVIN_W-1:0];
    end else if (pick >= 8) begin
      lo = longint'(sb.brk[0]) + longint'(KELVIN_OFFSET_Q4);
      hi = longint'(sb.brk[3]) + longint'(KELVIN_OFFSET_Q4);
      if (lo < 0) lo = 0;
      if (hi > 65535) hi = 65535;
      if (lo < hi) begin
        t = lo + longint'($urandom_range(int'(hi - lo)));
        kelvin = t[KELVIN_W-1:0];
      end
    end
    send_request(kelvin, cell_idx);
  endtask

  // Waits until every predicted result has come back.
  task automatic drain();
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  initial begin
    // Directed temperatures against the reset curve: the range ends, zero
    // Celsius, each breakpoint and the step just above it, and mid-segments.
    int unsigned directed_kelvin [16];
    idx_t        cell_idx;
    int          i, phase;
    directed_kelvin = '{0, 65535, 4370, 4369, 4770, 4771, 19410, 19411,
                        23810, 23811, 29970, 29971, 12000, 21000, 27000, 60000};
    sb            = new();
    cycles        = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_valid_i    <= 1'b0;
    temp_kelvin_i <= '0;
    cell_index_i  <= '0;
    out_ready_i   <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < 16; i++) begin
      case (i % 4)
        0: cell_idx = '0;
        1: cell_idx = '1;
        2: cell_idx = 20'h55555;
        default: cell_idx = 20'hAAAAA;
      endcase
      send_request(directed_kelvin[i][KELVIN_W-1:0], cell_idx);
    end
    in_valid_i <= 1'b0;

    // Each phase loads a new curve on an idle block, then streams requests
    // under its own mix of request gaps and result stalls.
    for (phase = 0; phase < PHASES; phase++) begin
      drain();
      load_curve(phase);
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 66; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 66; end
        default: begin send_idle_pct = 23; stall_pct = 23; end
      endcase
      repeat (PHASE_ITEMS) send_random_item();
      in_valid_i <= 1'b0;
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("piecewise_linear_modulus_test: done, clean");
    end else begin
      $display("piecewise_linear_modulus_test: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
src/plm_pkg.sv
src/plm_regs.sv
src/plm_front.sv
src/plm_div_stage.sv
src/plm_finish.sv
src/piecewise_linear_modulus.sv
bench/piecewise_linear_modulus_test.sv
